@@ rtl/mqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Memory quota table package
// Shared types, codes and sizes for the memory quota table unit.
// ----------------------------------------------------------------------------
package mqt_pkg;

   // Number of grant slots in the table.
   localparam int TABLE_ENTRIES = 16;
   localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // Request queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int PID_W    = 16;
   localparam int AMOUNT_W = 20;

   // Function codes on the request port.
   localparam logic [1:0] FUNC_CHECK   = 2'd0;
   localparam logic [1:0] FUNC_ALLOC   = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;

   // Status codes on the response port.
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_INSUFFICIENT = 3'd1;
   localparam logic [2:0] ST_FULL         = 3'd2;
   localparam logic [2:0] ST_RELEASED     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd4;

   typedef struct packed {
      logic [1:0]          func;
      logic [PID_W-1:0]    process_id;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [AMOUNT_W-1:0] freed_amount;
      logic [AMOUNT_W-1:0] total_in_use;
   } rsp_type;

   // Decoded operation carried through the queue.
   typedef enum logic [1:0] {
      OP_CHECK,
      OP_ALLOC,
      OP_RELEASE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PID_W-1:0]    process_id;
      logic [AMOUNT_W-1:0] amount;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MATCH,
      BK_UPDATE
   } back_state_type;

endpackage

@@ rtl/mqt_front.sv @@
// ----------------------------------------------------------------------------
// Memory quota table front end
// Accepts requests, decodes the function code and queues the commands.
// ----------------------------------------------------------------------------
module mqt_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mqt_pkg::req_type req_payload,
   input  logic            cmd_pop,
   output logic            cmd_valid,
   output mqt_pkg::cmd_type cmd
);
   import mqt_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   cmd_type             decoded;

   // The unused function code behaves as a check.
   always_comb begin
      decoded.process_id = req_payload.process_id;
      decoded.amount     = req_payload.amount;
      unique case (req_payload.func)
         FUNC_ALLOC:   decoded.op = OP_ALLOC;
         FUNC_RELEASE: decoded.op = OP_RELEASE;
         default:      decoded.op = OP_CHECK;
      endcase
   end

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ rtl/mqt_back.sv @@
// ----------------------------------------------------------------------------
// Memory quota table back end
// Looks up the grant table, tests the budget and applies each command.
// ----------------------------------------------------------------------------
module mqt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mqt_pkg::AMOUNT_W-1:0]  budget,
   input  logic                          cmd_valid,
   input  mqt_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   output mqt_pkg::rsp_type              rsp_payload
);
   import mqt_pkg::*;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;

   logic                 slot_valid_ff [TABLE_ENTRIES];
   logic [PID_W-1:0]     slot_process_ff [TABLE_ENTRIES];
   logic [AMOUNT_W-1:0]  slot_amount_ff [TABLE_ENTRIES];
   logic [AMOUNT_W-1:0]  used_ff, used_in;

   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic                 hit_any;
   logic [SLOT_W-1:0]    hit_idx;
   logic                 free_any;
   logic [SLOT_W-1:0]    free_idx;
   logic [AMOUNT_W:0]    wide_sum;

   logic                 hit_any_ff;
   logic [SLOT_W-1:0]    hit_idx_ff;
   logic                 free_any_ff;
   logic [SLOT_W-1:0]    free_idx_ff;
   logic                 fits_ff;
   logic [AMOUNT_W-1:0]  old_amount_ff;

   logic                 wr_en;
   logic                 wr_new;
   logic                 clr_en;
   logic [SLOT_W-1:0]    wr_idx;
   logic                 rsp_valid_in, rsp_valid_ff;
   rsp_type              rsp_in, rsp_ff;

   // Parallel match against every slot, lowest index wins.
   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = slot_valid_ff[i] && (slot_process_ff[i] == cmd_ff.process_id);
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
      wide_sum = {1'b0, used_ff} + {1'b0, cmd_ff.amount};
   end

   always_comb begin
      state_in     = state_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_new       = 1'b0;
      clr_en       = 1'b0;
      wr_idx       = hit_idx_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_in.status       = ST_OK;
      rsp_in.freed_amount = '0;
      rsp_in.total_in_use = used_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = BK_MATCH;
            end
         end
         BK_MATCH: begin
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            state_in     = BK_IDLE;
            rsp_valid_in = 1'b1;
            unique case (cmd_ff.op)
               OP_ALLOC: begin
                  if (!fits_ff) begin
                     rsp_in.status = ST_INSUFFICIENT;
                  end else if (hit_any_ff) begin
                     wr_en   = 1'b1;
                     used_in = used_ff - old_amount_ff + cmd_ff.amount;
                  end else if (free_any_ff) begin
                     wr_en   = 1'b1;
                     wr_new  = 1'b1;
                     wr_idx  = free_idx_ff;
                     used_in = used_ff + cmd_ff.amount;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               OP_RELEASE: begin
                  if (hit_any_ff) begin
                     clr_en              = 1'b1;
                     rsp_in.status       = ST_RELEASED;
                     rsp_in.freed_amount = old_amount_ff;
                     used_in = (used_ff >= old_amount_ff) ? used_ff - old_amount_ff : '0;
                  end else begin
                     rsp_in.status = ST_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_in.status = fits_ff ? ST_OK : ST_INSUFFICIENT;
               end
            endcase
            rsp_in.total_in_use = used_in;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_new) begin
            slot_valid_ff[wr_idx] <= 1'b1;
         end
         if (clr_en) begin
            slot_valid_ff[hit_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      if (state_ff == BK_MATCH) begin
         hit_any_ff    <= hit_any;
         hit_idx_ff    <= hit_idx;
         free_any_ff   <= free_any;
         free_idx_ff   <= free_idx;
         fits_ff       <= (wide_sum <= {1'b0, budget});
         old_amount_ff <= slot_amount_ff[hit_idx];
      end
      if (wr_en) begin
         slot_amount_ff[wr_idx] <= cmd_ff.amount;
      end
      if (wr_new) begin
         slot_process_ff[wr_idx] <= cmd_ff.process_id;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A response is only produced by the update step.
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == BK_UPDATE))
      else $error("response without an update step");

   // A process id is held by at most one valid slot.
   a_unique_pid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MATCH) |-> $onehot0(hit_vec))
      else $error("process id matches several slots");

   // Table full is only reported when every slot is taken.
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_FULL) |->
         ($countones(hit_vec | ~hit_vec) == TABLE_ENTRIES) && !free_any)
      else $error("table full reported with a free slot");

   // A new command is only taken while the back end is idle.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == BK_IDLE) && cmd_valid)
      else $error("command taken while busy");
`endif

endmodule

@@ rtl/memory_quota_table_unit.sv @@
// ----------------------------------------------------------------------------
// Memory quota table unit
// Per-process memory grants checked against a programmable global budget.
// ----------------------------------------------------------------------------
// A request (check, allocate or release) is accepted when start is high and
// busy is low. Each request gives exactly one response, shown for a single
// cycle with rsp_valid high; the receiver cannot stall, so it must take the
// response in that cycle. The back end takes each request through the queue
// pop, table match and table update steps before it pops the next one. Up to
// two requests wait in the queue between the front and back ends; busy rises
// while that queue is full. The budget register is written through the csr
// port, which is always ready, and should only be changed while no request is
// outstanding. Grant slots are marked empty by reset, so no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module memory_quota_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mqt_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   output mqt_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mqt_pkg::AMOUNT_W-1:0]  csr_wdata
);
   import mqt_pkg::*;

   // Budget register, cleared by reset.
   logic [AMOUNT_W-1:0] budget_ff, budget_in;

   // Queue interface between the two halves.
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   assign csr_ready = 1'b1;
   assign budget_in = (csr_valid && csr_ready) ? csr_wdata : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
      end else begin
         budget_ff <= budget_in;
      end
   end

   // The front end decodes each request and holds it until the back end
   // is free.
   mqt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .cmd_pop     (cmd_pop),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   // The back end owns the grant table and the running total.
   mqt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .budget      (budget_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
